@@ rtl/wsp_pkg.sv @@
// Shared types and constants for the WAV stream player.
package wsp_pkg;

  localparam int TONE_COUNT_BITS_DEF = 32;

  localparam int VOLUME_W = 7;
  localparam int RATE_W   = 18;
  localparam int CFG_W    = 18;

  localparam logic [VOLUME_W-1:0] VOLUME_RST = 7'd100;
  localparam logic [VOLUME_W-1:0] VOLUME_MAX = 7'd100;
  localparam logic [RATE_W-1:0]   RATE_RST   = 18'd16000;

  // Configuration register indexes
  localparam logic REG_VOLUME = 1'b0;
  localparam logic REG_RATE   = 1'b1;

  // Operation codes
  localparam logic [2:0] OP_NEW     = 3'd0;
  localparam logic [2:0] OP_BYTE    = 3'd1;
  localparam logic [2:0] OP_EOF     = 3'd2;
  localparam logic [2:0] OP_TICK    = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  // Event codes
  localparam logic [2:0] EV_SAMPLE      = 3'd0;
  localparam logic [2:0] EV_STARTED     = 3'd1;
  localparam logic [2:0] EV_INVALID     = 3'd2;
  localparam logic [2:0] EV_UNSUPPORTED = 3'd3;
  localparam logic [2:0] EV_COMPLETE    = 3'd4;

  // Divide by 100: floor(m * DIV100_MUL / 2^DIV100_SHIFT) is exact for m < 2^22
  localparam int          DIV100_SHIFT = 29;
  localparam logic [22:0] DIV100_MUL   = 23'd5368710;

  localparam int TONE_AMP = 5000;

  typedef enum logic [1:0] {
    TONE_NONE,
    TONE_NEG,
    TONE_POS
  } tone_sel_t;

  typedef struct packed {
    logic               has;
    logic [2:0]         ev;
    logic signed [15:0] pcm;
    tone_sel_t          tone;
  } item_res_t;

endpackage

@@ rtl/wsp_in_if.sv @@
// Input channel: one operation with its file byte and tone flag.
interface wsp_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] data_byte;
  logic       tone_on;

  modport source (output valid, output operation, output data_byte, output tone_on,
                  input ready);
  modport sink (input valid, input operation, input data_byte, input tone_on,
                output ready);
endinterface

@@ rtl/wsp_out_if.sv @@
// Output channel: one event with its sample.
interface wsp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_res;
  logic signed [15:0] sample;

  modport source (output valid, output event_res, output sample, input ready);
  modport sink (input valid, input event_res, input sample, output ready);
endinterface

@@ rtl/wav_stream_player.sv @@
// Top level of the WAV stream player: input register, parser and sample pipeline.
// Path: a result passes from the input register through the parser into the mixer stages.
// Throughput: one input item per cycle while the output is not stalled; the parser state updates once per item.
// Backpressure: pipeline stages hold on a stalled output; bubbles still collapse.
// Reset: synchronous, clears parser state, tone counter and all valid bits;
// volume returns to 100 and expected_rate to 16000.
module wav_stream_player #(
  parameter int TONE_COUNT_BITS = wsp_pkg::TONE_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [wsp_pkg::CFG_W-1:0] cfg_data,
  wsp_in_if.sink                    in_ch,
  wsp_out_if.source                 out_ch
);

  logic [wsp_pkg::VOLUME_W-1:0] volume;
  logic [wsp_pkg::RATE_W-1:0]   expected_rate;

  logic       v0;
  logic [2:0] op0;
  logic [7:0] byte0;
  logic       tone0;

  logic               mix_ready;
  logic               proc;
  wsp_pkg::item_res_t res;

  assign proc        = v0 && mix_ready;
  assign in_ch.ready = !v0 || mix_ready;

  // Volume writes whose low seven bits exceed 100 clamp to 100; the upper bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      volume        <= wsp_pkg::VOLUME_RST;
      expected_rate <= wsp_pkg::RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wsp_pkg::REG_VOLUME: begin
          volume <= (cfg_data[wsp_pkg::VOLUME_W-1:0] > wsp_pkg::VOLUME_MAX)
                    ? wsp_pkg::VOLUME_MAX : cfg_data[wsp_pkg::VOLUME_W-1:0];
        end
        wsp_pkg::REG_RATE: begin
          expected_rate <= cfg_data[wsp_pkg::RATE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      v0 <= 1'b1;
    end else if (proc) begin
      v0 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op0   <= in_ch.operation;
      byte0 <= in_ch.data_byte;
      tone0 <= in_ch.tone_on;
    end
  end

  wsp_parser #(
    .TONE_COUNT_BITS (TONE_COUNT_BITS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .en            (proc),
    .operation     (op0),
    .data_byte     (byte0),
    .tone_on       (tone0),
    .expected_rate (expected_rate),
    .res           (res)
  );

  wsp_mixer u_mixer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (proc && res.has),
    .in_ready (mix_ready),
    .res      (res),
    .volume   (volume),
    .out_ch   (out_ch)
  );

endmodule

@@ rtl/wsp_parser.sv @@
// RIFF/WAVE header and chunk parser with tone phase tracking.
module wsp_parser #(
  parameter int TONE_COUNT_BITS = wsp_pkg::TONE_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [2:0]                        operation,
  input  logic [7:0]                        data_byte,
  input  logic                              tone_on,
  input  logic [wsp_pkg::RATE_W-1:0]        expected_rate,
  output wsp_pkg::item_res_t                res
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RIFF_TAG,
    PH_RIFF_SIZE,
    PH_WAVE_TAG,
    PH_CHUNK_ID,
    PH_CHUNK_SIZE,
    PH_FMT_BODY,
    PH_SKIP,
    PH_PLAY
  } phase_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  phase_t                     phase, phase_next;
  logic [3:0]                 bidx, bidx_next;
  logic [31:0]                accum, accum_next;
  logic [31:0]                csize, csize_next;
  logic                       format_ok, format_ok_next;
  logic                       fields_ok, fields_ok_next;
  logic [8:0]                 hold, hold_next;
  logic [TONE_COUNT_BITS-1:0] tcount, tcount_next;
  logic [3:0]                 tsub, tsub_next;
  logic                       tphase, tphase_next;

  logic                       tone_fire;
  logic                       tone_clr;
  logic [1:0]                 fmt_pos;
  logic                       fok;
  logic [31:0]                skip_size;

  function automatic logic [31:0] gather(input logic [31:0] acc, input logic [1:0] pos,
                                         input logic [7:0] b);
    logic [31:0] r;
    case (pos)
      2'd0:    r = {24'd0, b};
      2'd1:    r = acc | {16'd0, b, 8'd0};
      2'd2:    r = acc | {8'd0, b, 16'd0};
      2'd3:    r = acc | {b, 24'd0};
      default: r = acc;
    endcase
    return r;
  endfunction

  assign fmt_pos   = (bidx >= 4'd4 && bidx < 4'd8) ? bidx[1:0] : {1'b0, bidx[0]};
  assign skip_size = (csize != 32'd0) ? csize - 32'd1 : csize;

  always_comb begin
    phase_next     = phase;
    bidx_next      = bidx;
    accum_next     = accum;
    csize_next     = csize;
    format_ok_next = format_ok;
    fields_ok_next = fields_ok;
    hold_next      = hold;
    tone_fire      = 1'b0;
    tone_clr       = 1'b0;
    fok            = fields_ok;
    res            = '0;
    res.ev         = wsp_pkg::EV_SAMPLE;
    res.tone       = wsp_pkg::TONE_NONE;

    case (operation)
      wsp_pkg::OP_NEW: begin
        phase_next     = PH_RIFF_TAG;
        bidx_next      = 4'd0;
        hold_next      = 9'd0;
        format_ok_next = 1'b0;
        fields_ok_next = 1'b0;
        accum_next     = 32'd0;
        csize_next     = 32'd0;
      end

      wsp_pkg::OP_BYTE: begin
        case (phase)
          PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
            accum_next = gather(accum, bidx[1:0], data_byte);
            if (bidx < 4'd3) begin
              bidx_next = bidx + 4'd1;
            end else begin
              bidx_next = 4'd0;
              if (phase == PH_RIFF_TAG) begin
                if (accum_next != TAG_RIFF) begin
                  phase_next = PH_IDLE;
                  hold_next  = 9'd0;
                  res.has    = 1'b1;
                  res.ev     = wsp_pkg::EV_INVALID;
                end else begin
                  phase_next = PH_RIFF_SIZE;
                end
              end else if (phase == PH_WAVE_TAG) begin
                if (accum_next != TAG_WAVE) begin
                  phase_next = PH_IDLE;
                  hold_next  = 9'd0;
                  res.has    = 1'b1;
                  res.ev     = wsp_pkg::EV_INVALID;
                end else begin
                  phase_next = PH_CHUNK_ID;
                end
              end else begin
                phase_next = PH_CHUNK_SIZE;
              end
            end
          end

          PH_RIFF_SIZE, PH_CHUNK_SIZE: begin
            csize_next = gather(csize, bidx[1:0], data_byte);
            if (bidx < 4'd3) begin
              bidx_next = bidx + 4'd1;
            end else begin
              bidx_next = 4'd0;
              if (phase == PH_RIFF_SIZE) begin
                if (csize_next == 32'd0) begin
                  phase_next = PH_IDLE;
                  hold_next  = 9'd0;
                  res.has    = 1'b1;
                  res.ev     = wsp_pkg::EV_INVALID;
                end else begin
                  phase_next = PH_WAVE_TAG;
                end
              end else if (accum == TAG_FMT) begin
                fields_ok_next = 1'b1;
                phase_next     = PH_FMT_BODY;
              end else if (accum == TAG_DATA && format_ok) begin
                hold_next  = 9'd0;
                phase_next = PH_PLAY;
                res.has    = 1'b1;
                res.ev     = wsp_pkg::EV_STARTED;
              end else begin
                phase_next = (csize_next == 32'd0) ? PH_CHUNK_ID : PH_SKIP;
              end
            end
          end

          PH_FMT_BODY: begin
            // Format and channels share the low half word, rate takes four bytes,
            // bits per sample arrive at the end; the rest is ignored.
            if (bidx < 4'd8 || bidx >= 4'd14) begin
              accum_next = gather(accum, fmt_pos, data_byte);
            end
            if ((bidx == 4'd1 || bidx == 4'd3) && accum_next != 32'd1) begin
              fok = 1'b0;
            end
            if (bidx == 4'd7 && accum_next != {14'd0, expected_rate}) begin
              fok = 1'b0;
            end
            if (bidx == 4'd15 && accum_next != 32'd16) begin
              fok = 1'b0;
            end
            fields_ok_next = fok;
            if (bidx < 4'd15) begin
              bidx_next = bidx + 4'd1;
            end else begin
              bidx_next      = 4'd0;
              format_ok_next = fok;
              if (csize > 32'd16) begin
                csize_next = csize - 32'd16;
                phase_next = PH_SKIP;
              end else begin
                phase_next = PH_CHUNK_ID;
              end
            end
          end

          PH_SKIP: begin
            csize_next = skip_size;
            if (skip_size == 32'd0) begin
              phase_next = PH_CHUNK_ID;
              bidx_next  = 4'd0;
            end
          end

          PH_PLAY: begin
            if (!hold[8]) begin
              hold_next = {1'b1, data_byte};
            end else begin
              hold_next = 9'd0;
              res.has   = 1'b1;
              res.ev    = wsp_pkg::EV_SAMPLE;
              res.pcm   = signed'({data_byte, hold[7:0]});
              tone_fire = tone_on;
            end
          end

          default: begin
          end
        endcase
      end

      wsp_pkg::OP_EOF: begin
        if (phase != PH_IDLE) begin
          phase_next = PH_IDLE;
          bidx_next  = 4'd0;
          hold_next  = 9'd0;
          res.has    = 1'b1;
          if (phase == PH_RIFF_TAG || phase == PH_RIFF_SIZE || phase == PH_WAVE_TAG) begin
            res.ev = wsp_pkg::EV_INVALID;
          end else if (phase == PH_PLAY) begin
            res.ev = wsp_pkg::EV_COMPLETE;
          end else begin
            res.ev = wsp_pkg::EV_UNSUPPORTED;
          end
        end
      end

      wsp_pkg::OP_TICK: begin
        if (phase != PH_PLAY && tone_on) begin
          res.has   = 1'b1;
          res.ev    = wsp_pkg::EV_SAMPLE;
          tone_fire = 1'b1;
        end
      end

      wsp_pkg::OP_RESTART: begin
        tone_clr = 1'b1;
      end

      default: begin
      end
    endcase

    if (tone_fire) begin
      res.tone = tphase ? wsp_pkg::TONE_POS : wsp_pkg::TONE_NEG;
    end
  end

  // Tone phase flips every ten tone samples; a counter wrap or a restart operation restarts the phase.
  always_comb begin
    tcount_next = tcount;
    tsub_next   = tsub;
    tphase_next = tphase;
    if (tone_clr || (tone_fire && tcount == '1)) begin
      tcount_next = '0;
      tsub_next   = 4'd0;
      tphase_next = 1'b0;
    end else if (tone_fire) begin
      tcount_next = tcount + TONE_COUNT_BITS'(1);
      if (tsub == 4'd9) begin
        tsub_next   = 4'd0;
        tphase_next = ~tphase;
      end else begin
        tsub_next = tsub + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      bidx      <= 4'd0;
      accum     <= 32'd0;
      csize     <= 32'd0;
      format_ok <= 1'b0;
      fields_ok <= 1'b0;
      hold      <= 9'd0;
      tcount    <= '0;
      tsub      <= 4'd0;
      tphase    <= 1'b0;
    end else if (en) begin
      phase     <= phase_next;
      bidx      <= bidx_next;
      accum     <= accum_next;
      csize     <= csize_next;
      format_ok <= format_ok_next;
      fields_ok <= fields_ok_next;
      hold      <= hold_next;
      tcount    <= tcount_next;
      tsub      <= tsub_next;
      tphase    <= tphase_next;
    end
  end

endmodule

@@ rtl/wsp_mixer.sv @@
// Three-stage gain, tone and saturation pipeline ending in the output register.
module wsp_mixer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  wsp_pkg::item_res_t           res,
  input  logic [wsp_pkg::VOLUME_W-1:0] volume,
  wsp_out_if.source                    out_ch
);

  logic                v1, v2, v3;
  logic                adv1, adv2, adv3;

  logic [2:0]          ev1, ev2, ev3;
  logic signed [23:0]  prod1;
  wsp_pkg::tone_sel_t  tone1, tone2;
  logic                neg2;
  logic [44:0]         q2;
  logic signed [15:0]  smp3;

  logic signed [23:0]  pcm_x;
  logic signed [23:0]  vol_x;
  logic [23:0]         absv;
  logic [15:0]         quo;
  logic signed [17:0]  base;
  logic signed [17:0]  tone_v;
  logic signed [17:0]  sum;
  logic signed [15:0]  sat;

  // A stage advances when it is empty or the next one is advancing too.
  assign adv3     = !v3 || out_ch.ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  assign pcm_x = 24'(res.pcm);
  assign vol_x = 24'(signed'({1'b0, volume}));

  assign absv = prod1[23] ? 24'(-prod1) : 24'(prod1);

  assign quo  = q2[wsp_pkg::DIV100_SHIFT +: 16];
  assign base = neg2 ? -signed'(18'(quo)) : signed'(18'(quo));

  always_comb begin
    case (tone2)
      wsp_pkg::TONE_POS: tone_v = 18'(wsp_pkg::TONE_AMP);
      wsp_pkg::TONE_NEG: tone_v = -18'(wsp_pkg::TONE_AMP);
      default:           tone_v = 18'sd0;
    endcase
  end

  assign sum = base + tone_v;

  always_comb begin
    if (sum > 18'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      ev1   <= res.ev;
      prod1 <= pcm_x * vol_x;
      tone1 <= res.tone;
    end
    if (adv2) begin
      ev2   <= ev1;
      tone2 <= tone1;
      neg2  <= prod1[23];
      q2    <= 45'(absv[21:0]) * 45'(wsp_pkg::DIV100_MUL);
    end
    if (adv3) begin
      ev3  <= ev2;
      smp3 <= sat;
    end
  end

  assign out_ch.valid     = v3;
  assign out_ch.event_res = ev3;
  assign out_ch.sample    = smp3;

endmodule

@@ bench/wav_stream_player_tb.sv @@
// Self-checking testbench for the WAV stream player: directed rows, then random WAV files.
module wav_stream_player_tb;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 225;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500_000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RIFF_ID,
    ST_RIFF_LEN,
    ST_WAVE_ID,
    ST_CHUNK_ID,
    ST_CHUNK_LEN,
    ST_FMT,
    ST_SKIP,
    ST_PLAY
  } parse_state_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       tone;
  } stim_item_t;

  typedef struct packed {
    logic [2:0]         ev;
    logic signed [15:0] smp;
  } outcome_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         data;
    logic               tone;
    logic               known;
    logic               has;
    logic [2:0]         ev;
    logic signed [15:0] smp;
  } script_row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [wsp_pkg::CFG_W-1:0] cfg_data;

  wsp_in_if  in_ch ();
  wsp_out_if out_ch ();

  wav_stream_player dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // Player model state
  parse_state_t   ph;
  logic [31:0]    field_pos;
  logic [31:0]    field_word;
  logic [31:0]    chunk_left;
  logic           fmt_valid;
  logic           fmt_checks;
  logic           in_playback;
  logic [8:0]     pending_low;
  logic [31:0]    tone_ticks;
  logic [6:0]     gain_pct;
  logic [17:0]    want_rate;

  outcome_t       due_events [$];
  stim_item_t     pending_ops [$];
  logic [7:0]     file_bytes [$];

  int unsigned    src_gap_max;
  int unsigned    sink_gap_max;
  int unsigned    tone_mode;
  int             hold_asks;
  int             fail_cnt;
  int             items_sent;
  int             events_seen;
  int             samples_seen;
  int             files_built;
  int             cycle_cnt;

  script_row_t opening_rows [0:24] = '{
    '{wsp_pkg::OP_BYTE,    8'hFF, 1'b0, 1'b1, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_EOF,     8'h00, 1'b0, 1'b1, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{OP_RSVD5,            8'h00, 1'b0, 1'b1, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{OP_RSVD6,            8'hFF, 1'b1, 1'b1, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{OP_RSVD7,            8'h00, 1'b0, 1'b1, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_TICK,    8'h00, 1'b0, 1'b1, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_TICK,    8'h00, 1'b1, 1'b1, 1'b1, wsp_pkg::EV_SAMPLE,  -16'sd5000},
    '{wsp_pkg::OP_RESTART, 8'h00, 1'b1, 1'b1, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_NEW,     8'h00, 1'b0, 1'b1, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_EOF,     8'h00, 1'b0, 1'b1, 1'b1, wsp_pkg::EV_INVALID, 16'sd0},
    '{wsp_pkg::OP_NEW,     8'h00, 1'b0, 1'b1, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h52, 1'b0, 1'b0, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h49, 1'b0, 1'b0, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h46, 1'b0, 1'b0, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h00, 1'b0, 1'b1, 1'b1, wsp_pkg::EV_INVALID, 16'sd0},
    '{wsp_pkg::OP_NEW,     8'h00, 1'b1, 1'b1, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h52, 1'b1, 1'b0, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h49, 1'b1, 1'b0, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h46, 1'b1, 1'b0, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h46, 1'b1, 1'b0, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h00, 1'b1, 1'b0, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h00, 1'b1, 1'b0, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h00, 1'b1, 1'b0, 1'b0, wsp_pkg::EV_SAMPLE,  16'sd0},
    '{wsp_pkg::OP_BYTE,    8'h00, 1'b1, 1'b1, 1'b1, wsp_pkg::EV_INVALID, 16'sd0},
    '{wsp_pkg::OP_TICK,    8'hFF, 1'b1, 1'b1, 1'b1, wsp_pkg::EV_SAMPLE,  -16'sd5000}
  };

  logic [17:0] phase_vol  [0:PHASES-1] = '{18'd100, 18'd0, 18'h3FFFF, 18'd1, 18'd57, 18'd99};
  logic [17:0] phase_rate [0:PHASES-1] = '{18'd16000, 18'd1, 18'h3FFFF, 18'd44100, 18'd48000,
                                           18'd192000};
  int unsigned phase_src  [0:PHASES-1] = '{0, 18, 0, 3, 18, 3};
  int unsigned phase_sink [0:PHASES-1] = '{0, 18, 8, 18, 0, 3};

  function automatic logic [31:0] merge_byte(input logic [31:0] acc, input logic [31:0] pos,
                                             input logic [7:0] b);
    logic [1:0] p;
    p = pos[1:0];
    if (p == 2'd0) return {24'd0, b};
    return acc | ({24'd0, b} << (8 * p));
  endfunction

  function automatic void drop_to_idle();
    ph          = ST_IDLE;
    field_pos   = '0;
    in_playback = 1'b0;
    pending_low = '0;
  endfunction

  // Scale by volume, add the square wave while the tone is on, then saturate.
  function automatic logic signed [15:0] mix_sample(input int pcm, input logic tone);
    int s;
    s = (pcm * int'(gain_pct)) / 100;
    if (tone) begin
      s += (((tone_ticks / 10) % 2) == 1) ? wsp_pkg::TONE_AMP : -wsp_pkg::TONE_AMP;
      tone_ticks = tone_ticks + 1;
    end
    if (s > 32767) s = 32767;
    else if (s < -32768) s = -32768;
    return 16'(s);
  endfunction

  task automatic predict_event(input stim_item_t it, output logic has, output outcome_t res);
    logic [31:0]  pos;
    logic [15:0]  raw;
    parse_state_t was;
    has = 1'b0;
    res = '{wsp_pkg::EV_SAMPLE, 16'sd0};
    pos = field_pos;
    case (it.op)
      wsp_pkg::OP_NEW: begin
        drop_to_idle();
        fmt_valid  = 1'b0;
        fmt_checks = 1'b0;
        field_word = '0;
        chunk_left = '0;
        ph         = ST_RIFF_ID;
      end
      wsp_pkg::OP_BYTE: begin
        case (ph)
          ST_RIFF_ID, ST_WAVE_ID, ST_CHUNK_ID: begin
            field_word = merge_byte(field_word, pos, it.data);
            if (pos < 3) begin
              field_pos = pos + 1;
            end else begin
              field_pos = '0;
              if (ph == ST_RIFF_ID) begin
                if (field_word != TAG_RIFF) begin
                  drop_to_idle();
                  has    = 1'b1;
                  res.ev = wsp_pkg::EV_INVALID;
                end else ph = ST_RIFF_LEN;
              end else if (ph == ST_WAVE_ID) begin
                if (field_word != TAG_WAVE) begin
                  drop_to_idle();
                  has    = 1'b1;
                  res.ev = wsp_pkg::EV_INVALID;
                end else ph = ST_CHUNK_ID;
              end else ph = ST_CHUNK_LEN;
            end
          end
          ST_RIFF_LEN, ST_CHUNK_LEN: begin
            chunk_left = merge_byte(chunk_left, pos, it.data);
            if (pos < 3) begin
              field_pos = pos + 1;
            end else begin
              field_pos = '0;
              if (ph == ST_RIFF_LEN) begin
                if (chunk_left == 0) begin
                  drop_to_idle();
                  has    = 1'b1;
                  res.ev = wsp_pkg::EV_INVALID;
                end else ph = ST_WAVE_ID;
              end else if (field_word == TAG_FMT) begin
                fmt_checks = 1'b1;
                ph         = ST_FMT;
              end else if (field_word == TAG_DATA && fmt_valid) begin
                in_playback = 1'b1;
                pending_low = '0;
                ph          = ST_PLAY;
                has         = 1'b1;
                res.ev      = wsp_pkg::EV_STARTED;
              end else begin
                ph = (chunk_left == 0) ? ST_CHUNK_ID : ST_SKIP;
              end
            end
          end
          ST_FMT: begin
            // format and channels take two bytes each, rate four, bits two at the end
            if (pos < 8) begin
              field_word = merge_byte(field_word, (pos < 4) ? (pos & 1) : (pos - 4), it.data);
            end else if (pos >= 14) begin
              field_word = merge_byte(field_word, pos - 14, it.data);
            end
            if ((pos == 1 || pos == 3) && field_word != 1) fmt_checks = 1'b0;
            if (pos == 7 && field_word != {14'd0, want_rate}) fmt_checks = 1'b0;
            if (pos == 15 && field_word != 16) fmt_checks = 1'b0;
            if (pos < 15) begin
              field_pos = pos + 1;
            end else begin
              field_pos = '0;
              fmt_valid = fmt_checks;
              if (chunk_left > 16) begin
                chunk_left = chunk_left - 16;
                ph         = ST_SKIP;
              end else ph = ST_CHUNK_ID;
            end
          end
          ST_SKIP: begin
            if (chunk_left != 0) chunk_left = chunk_left - 1;
            if (chunk_left == 0) begin
              ph        = ST_CHUNK_ID;
              field_pos = '0;
            end
          end
          ST_PLAY: begin
            if (!pending_low[8]) begin
              pending_low = {1'b1, it.data};
            end else begin
              raw         = {it.data, pending_low[7:0]};
              pending_low = '0;
              has         = 1'b1;
              res.smp     = mix_sample(int'($signed(raw)), it.tone);
            end
          end
          default: ;
        endcase
      end
      wsp_pkg::OP_EOF: begin
        if (ph != ST_IDLE) begin
          was = ph;
          drop_to_idle();
          has = 1'b1;
          if (was == ST_RIFF_ID || was == ST_RIFF_LEN || was == ST_WAVE_ID) begin
            res.ev = wsp_pkg::EV_INVALID;
          end else if (was == ST_PLAY) res.ev = wsp_pkg::EV_COMPLETE;
          else res.ev = wsp_pkg::EV_UNSUPPORTED;
        end
      end
      wsp_pkg::OP_TICK: begin
        if (!in_playback && it.tone) begin
          has     = 1'b1;
          res.smp = mix_sample(0, 1'b1);
        end
      end
      wsp_pkg::OP_RESTART: tone_ticks = '0;
      default: ;
    endcase
  endtask

  function automatic logic pick_tone();
    if (tone_mode == 2) return logic'($urandom_range(0, 1));
    return tone_mode[0];
  endfunction

  task automatic queue_op(input logic [2:0] op, input logic [7:0] b);
    pending_ops.push_back(stim_item_t'{op, b, pick_tone()});
  endtask

  task automatic put_le(input logic [31:0] v, input int nbytes);
    for (int k = 0; k < nbytes; k++) file_bytes.push_back(v[8*k +: 8]);
  endtask

  task automatic queue_side_op();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 4: queue_op(wsp_pkg::OP_TICK, 8'($urandom));
      5, 6:          queue_op(wsp_pkg::OP_RESTART, 8'($urandom));
      7:             queue_op(OP_RSVD5, 8'($urandom));
      8:             queue_op(OP_RSVD6, 8'($urandom));
      default:       queue_op(OP_RSVD7, 8'($urandom));
    endcase
  endtask

  // Build one WAV file, mostly well formed, and queue it as operations.
  task automatic build_file();
    int unsigned kind;
    int unsigned n;
    int unsigned flaw;
    int unsigned fmt_size;
    int unsigned cut;
    logic [31:0] word;
    bit          fmt_good;
    file_bytes.delete();
    files_built++;
    tone_mode = $urandom_range(0, 2);
    kind      = $urandom_range(0, 99);
    fmt_good  = 1'b0;
    queue_op(wsp_pkg::OP_NEW, 8'($urandom));
    if (kind < 6) begin
      n = $urandom_range(1, 12);
      repeat (n) put_le($urandom, 1);
    end else begin
      word = TAG_RIFF;
      if (kind < 12) word ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
      put_le(word, 4);
      word = $urandom;
      if (word == 0 || kind < 17) word = (kind < 12) ? 32'd1 + word[7:0] : 32'd0;
      put_le(word, 4);
      word = TAG_WAVE;
      if (kind >= 17 && kind < 23) begin
        word ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
      end
      put_le(word, 4);
      // leading chunk: unknown id, or a data chunk before any format
      if ($urandom_range(0, 2) == 0) begin
        put_le(($urandom_range(0, 1) == 1) ? TAG_DATA : $urandom, 4);
        n = $urandom_range(0, 5);
        put_le(n, 4);
        repeat (n) put_le($urandom, 1);
      end
      if ($urandom_range(0, 9) != 0) begin
        put_le(TAG_FMT, 4);
        fmt_size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 22) : 16;
        put_le(fmt_size, 4);
        flaw = $urandom_range(0, 11);
        put_le((flaw == 0) ? 32'd1 ^ (32'd1 << $urandom_range(0, 15)) : 32'd1, 2);
        put_le((flaw == 1) ? 32'd1 ^ (32'd1 << $urandom_range(0, 15)) : 32'd1, 2);
        word = {14'd0, want_rate};
        if (flaw == 2) word ^= 32'd1 << $urandom_range(0, 31);
        put_le(word, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le((flaw == 3) ? 32'd16 ^ (32'd1 << $urandom_range(0, 15)) : 32'd16, 2);
        if (fmt_size > 16) repeat (fmt_size - 16) put_le($urandom, 1);
        fmt_good = (flaw > 3);
        if ($urandom_range(0, 4) == 0) begin
          put_le($urandom, 4);
          n = $urandom_range(0, 5);
          put_le(n, 4);
          repeat (n) put_le($urandom, 1);
        end
      end
      put_le(TAG_DATA, 4);
      if (fmt_good && kind >= 23) begin
        put_le($urandom, 4);
        n = $urandom_range(0, 14);
        repeat (n) begin
          case ($urandom_range(0, 7))
            0:       word = 32'h7FFF;
            1:       word = 32'h8000;
            2:       word = 32'hFFFF;
            3:       word = 32'h0000;
            default: word = $urandom;
          endcase
          put_le(word, 2);
        end
        // odd trailing byte gets dropped at end of file
        if ($urandom_range(0, 3) == 0) put_le($urandom, 1);
      end else begin
        n = $urandom_range(0, 5);
        put_le(n, 4);
        repeat (n) put_le($urandom, 1);
      end
    end
    if ($urandom_range(0, 6) == 0 && file_bytes.size() > 0) begin
      cut = $urandom_range(0, file_bytes.size() - 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
    foreach (file_bytes[k]) begin
      if ($urandom_range(0, 15) == 0) queue_side_op();
      queue_op(wsp_pkg::OP_BYTE, file_bytes[k]);
    end
    if ($urandom_range(0, 9) != 0) queue_op(wsp_pkg::OP_EOF, 8'($urandom));
    if ($urandom_range(0, 3) == 0) queue_op(wsp_pkg::OP_BYTE, 8'($urandom));
    if ($urandom_range(0, 3) == 0) queue_side_op();
  endtask

  task automatic transfer_in(input stim_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= it.op;
    in_ch.data_byte <= it.data;
    in_ch.tone_on   <= it.tone;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [17:0] vol_word, input logic [17:0] rate_word);
    cfg_we    <= 1'b1;
    cfg_index <= wsp_pkg::REG_VOLUME;
    cfg_data  <= vol_word;
    @(posedge clk);
    cfg_index <= wsp_pkg::REG_RATE;
    cfg_data  <= rate_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gain_pct  = (vol_word[6:0] > wsp_pkg::VOLUME_MAX) ? wsp_pkg::VOLUME_MAX : vol_word[6:0];
    want_rate = rate_word;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d events still owed", $time, due_events.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned gap;
    outcome_t    want;
    int          hold_served;
    hold_served  = 0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_asks != hold_served) begin
        gap = LONG_HOLD;
        hold_served++;
      end else gap = $urandom_range(0, sink_gap_max);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      events_seen++;
      if (out_ch.event_res == wsp_pkg::EV_SAMPLE) samples_seen++;
      if (due_events.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected event %0d sample %0d", $time, out_ch.event_res,
                 out_ch.sample);
      end else begin
        want = due_events.pop_front();
        if (out_ch.event_res !== want.ev) begin
          fail_cnt++;
          $display("%0t: event_res expected %0d actual %0d", $time, want.ev, out_ch.event_res);
        end
        if (out_ch.sample !== want.smp) begin
          fail_cnt++;
          $display("%0t: sample expected %0d actual %0d", $time, want.smp, out_ch.sample);
        end
      end
    end
  end

  initial begin : stimulus
    script_row_t row;
    logic        has;
    outcome_t    res;
    logic [17:0] vol_word;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = wsp_pkg::REG_VOLUME;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = wsp_pkg::OP_NEW;
    in_ch.data_byte = '0;
    in_ch.tone_on   = 1'b0;
    hold_asks       = 0;
    fail_cnt        = 0;
    items_sent      = 0;
    events_seen     = 0;
    samples_seen    = 0;
    files_built     = 0;
    tone_mode       = 0;
    field_word      = '0;
    chunk_left      = '0;
    fmt_valid       = 1'b0;
    fmt_checks      = 1'b0;
    tone_ticks      = '0;
    gain_pct        = wsp_pkg::VOLUME_RST;
    want_rate       = wsp_pkg::RATE_RST;
    drop_to_idle();
    src_gap_max     = 3;
    sink_gap_max    = 3;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      transfer_in(stim_item_t'{row.op, row.data, row.tone});
      predict_event(stim_item_t'{row.op, row.data, row.tone}, has, res);
      if (row.known) begin
        if (row.has) due_events.push_back(outcome_t'{row.ev, row.smp});
      end else if (has) due_events.push_back(res);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      vol_word = phase_vol[p];
      if (p == 4) vol_word = 18'($urandom_range(2, 98));
      set_config(vol_word, phase_rate[p]);
      src_gap_max  = phase_src[p];
      sink_gap_max = phase_sink[p];
      // hold the output off while the input keeps offering items
      if (p == 2) hold_asks++;
      pending_ops.delete();
      while (pending_ops.size() < PHASE_ITEMS) build_file();
      foreach (pending_ops[k]) begin
        transfer_in(pending_ops[k]);
        predict_event(pending_ops[k], has, res);
        if (has) due_events.push_back(res);
      end
    end

    in_ch.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Sent %0d transfers from %0d generated files; checked %0d events, %0d samples",
             items_sent, files_built, events_seen, samples_seen);
    $display("Volume ran from 0 to a clamped 127, rate from 1 to the 18-bit maximum");
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/wsp_pkg.sv
rtl/wsp_in_if.sv
rtl/wsp_out_if.sv
rtl/wsp_parser.sv
rtl/wsp_mixer.sv
rtl/wav_stream_player.sv
bench/wav_stream_player_tb.sv
